>>> rtl/core/lbcu_pkg.sv
// Shared types and constants for the line-buffered console UART.
`default_nettype none

package lbcu_pkg;

    localparam int LINE_BUFFER_SIZE_DEFAULT = 64;
    localparam int APB_ADDR_WIDTH = 4;
    localparam int APB_DATA_WIDTH = 32;
    localparam int OFFSET_WIDTH = 12;
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int CMD_QUEUE_AW = $clog2(CMD_QUEUE_DEPTH);

    localparam logic FUNC_READ = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    localparam logic [7:0] CHAR_MASK = 8'hFF;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef enum logic [1:0] {
        REG_BASE_ADDRESS  = 2'd0,
        REG_DATA_OFFSET   = 2'd1,
        REG_STATUS_OFFSET = 2'd2,
        REG_STATUS_VALUE  = 2'd3
    } reg_index_t;

    typedef enum logic {
        CMD_READ = 1'b0,
        CMD_CHAR = 1'b1
    } cmd_op_t;

    typedef struct packed {
        logic        func;
        logic [31:0] address;
        logic [31:0] write_data;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] read_data;
        logic [7:0]  line_char;
        logic        last;
    } out_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [31:0] data;
    } cmd_t;

    typedef struct packed {
        logic [31:0]             base_address;
        logic [OFFSET_WIDTH-1:0] data_offset;
        logic [OFFSET_WIDTH-1:0] status_offset;
        logic [31:0]             status_value;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/lbcu_ram.sv
// Generic single-port-write RAM with a registered read port.
`default_nettype none

module lbcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/lbcu_front.sv
// Front end: decodes each bus access into a command for the back end, or drops it.
`default_nettype none

module lbcu_front (
    input  wire logic          push,
    output logic               full,
    input  wire lbcu_pkg::in_t request,
    input  wire lbcu_pkg::cfg_t cfg,
    input  wire logic          q_full,
    output logic               q_push,
    output lbcu_pkg::cmd_t     q_cmd
);

    import lbcu_pkg::*;

    logic [32:0] status_diff;
    logic [32:0] data_diff;
    logic        status_hit;
    logic        data_hit;
    logic [7:0]  ch;
    logic        printable;

    // An address below the base borrows and so never matches.
    assign status_diff = {1'b0, request.address} - {1'b0, cfg.base_address};
    assign data_diff = {1'b0, request.address} - {1'b0, cfg.base_address};
    assign status_hit = !status_diff[32]
        && (status_diff[31:0] == {{(32-OFFSET_WIDTH){1'b0}}, cfg.status_offset});
    assign data_hit = !data_diff[32]
        && (data_diff[31:0] == {{(32-OFFSET_WIDTH){1'b0}}, cfg.data_offset});

    assign ch = request.write_data[7:0] & CHAR_MASK;
    assign printable = ((ch >= CH_SPACE) && (ch <= CH_TILDE))
        || (ch == CH_NEWLINE) || (ch == CH_TAB);

    assign full = q_full;

    always_comb
    begin
        q_cmd = '{op: CMD_READ, data: 32'd0};
        q_push = 1'b0;
        if (request.func == FUNC_READ)
        begin
            q_cmd.op = CMD_READ;
            q_cmd.data = status_hit ? cfg.status_value : 32'd0;
            q_push = push && !q_full;
        end
        else
        begin
            q_cmd.op = CMD_CHAR;
            q_cmd.data = {24'd0, ch};
            q_push = push && !q_full && data_hit && printable;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lbcu_cmd_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module lbcu_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lbcu_pkg::cmd_t wr_cmd,
    output logic                full,
    input  wire logic           pop,
    output lbcu_pkg::cmd_t      rd_cmd,
    output logic                empty
);

    import lbcu_pkg::*;

    cmd_t                      entry_reg [CMD_QUEUE_DEPTH];
    logic [CMD_QUEUE_AW-1:0]   wr_ptr_reg;
    logic [CMD_QUEUE_AW-1:0]   rd_ptr_reg;
    logic [CMD_QUEUE_AW:0]     count_reg;
    logic                      do_push;
    logic                      do_pop;

    assign full = (count_reg == (CMD_QUEUE_AW+1)'(CMD_QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (CMD_QUEUE_AW+1)'(CMD_QUEUE_DEPTH))
        else $error("command queue count exceeds its depth");

endmodule

`default_nettype wire

>>> rtl/core/lbcu_back.sv
// Back end: answers reads, collects characters in the line store and drains flushed lines.
`default_nettype none

module lbcu_back #(
    parameter int LINE_BUFFER_SIZE = lbcu_pkg::LINE_BUFFER_SIZE_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lbcu_pkg::cmd_t cmd,
    input  wire logic           cmd_empty,
    output logic                cmd_pop,
    output logic                empty,
    input  wire logic           pop,
    output lbcu_pkg::out_t      result
);

    import lbcu_pkg::*;

    localparam int AW = $clog2(LINE_BUFFER_SIZE);
    localparam logic [AW-1:0] LIMIT = AW'(LINE_BUFFER_SIZE - 2);
    localparam logic [AW-1:0] FILL_MAX = AW'(LINE_BUFFER_SIZE - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPEND,
        S_ISSUE,
        S_EMIT
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] fill_reg;
    logic [AW-1:0] idx_reg;
    out_t          out_reg;
    logic          out_valid_reg;

    logic          slot_free;
    logic          load_out;
    logic [7:0]    ch;
    logic [AW-1:0] slot;
    logic [AW-1:0] fill_inc;
    logic          is_newline;
    logic          flush;
    logic          last_char;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign slot_free = !out_valid_reg || pop;
    assign empty = !out_valid_reg;
    assign result = out_reg;

    assign ch = cmd.data[7:0];
    assign slot = (fill_reg >= LIMIT) ? LIMIT - 1'b1 : fill_reg;
    assign fill_inc = slot + 1'b1;
    assign is_newline = (ch == CH_NEWLINE);
    assign flush = (fill_inc == LIMIT) || is_newline;
    assign last_char = (idx_reg == fill_reg - 1'b1);

    assign cmd_pop = (state_reg == S_IDLE) && !cmd_empty
        && ((cmd.op == CMD_CHAR) || slot_free);

    assign load_out = (cmd_pop && (cmd.op == CMD_READ))
        || ((state_reg == S_EMIT) && slot_free);

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = slot;
        ram_wdata = ch;
        if (state_reg == S_APPEND)
        begin
            ram_we = 1'b1;
            ram_waddr = fill_reg;
            ram_wdata = CH_NEWLINE;
        end
        else if (cmd_pop && (cmd.op == CMD_CHAR))
        begin
            ram_we = 1'b1;
        end
    end

    lbcu_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BUFFER_SIZE)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        if (cmd.op == CMD_READ)
                        begin
                            out_reg <= '{kind: KIND_READ, read_data: cmd.data,
                                         line_char: 8'd0, last: 1'b1};
                        end
                        else
                        begin
                            fill_reg <= fill_inc;
                            if (flush)
                            begin
                                idx_reg <= '0;
                                state_reg <= is_newline ? S_ISSUE : S_APPEND;
                            end
                        end
                    end
                end
                S_APPEND:
                begin
                    fill_reg <= fill_reg + 1'b1;
                    state_reg <= S_ISSUE;
                end
                S_ISSUE:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_reg <= '{kind: KIND_CHAR, read_data: 32'd0,
                                     line_char: ram_rdata, last: last_char};
                        if (last_char)
                        begin
                            fill_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("line fill count ran past the store");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == S_IDLE))
        else $error("command taken while a line is draining");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && slot_free && last_char) |=>
            (fill_reg == '0 && state_reg == S_IDLE))
        else $error("line store not emptied after its last character");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (idx_reg < fill_reg))
        else $error("drain index beyond the filled part of the line");

endmodule

`default_nettype wire

>>> rtl/core/line_buffered_console_uart.sv
// Top level of the line-buffered console UART with its APB register port.
`default_nettype none

// Transmit-only console UART. Each beat pushed is one bus access: a read yields
// one response beat, which passes through the command queue and then the
// registered output slot, a write of a printable byte, newline or tab to the
// data address goes into the line store, and anything else is dropped with no
// beat. A newline, or a line that reaches LINE_BUFFER_SIZE - 2 characters (a
// newline is then added in S_APPEND), flushes the line: each character's read of
// the registered line store is issued and then used before the next one, and
// a full output slot stalls the drain. A two-entry command queue lets accesses be
// pushed while a line drains. The line store needs no clearing after reset.
module line_buffered_console_uart #(
    parameter int LINE_BUFFER_SIZE = lbcu_pkg::LINE_BUFFER_SIZE_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire lbcu_pkg::in_t                        request,
    output logic                                      empty,
    input  wire logic                                 pop,
    output lbcu_pkg::out_t                            result,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [lbcu_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  wire logic [lbcu_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic      [lbcu_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                      pready
);

    import lbcu_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t reg_sel;
    logic       cfg_write;
    logic       q_push;
    logic       q_full;
    cmd_t       q_wr_cmd;
    cmd_t       q_rd_cmd;
    logic       q_empty;
    logic       q_pop;

    assign pready = 1'b1;
    assign reg_sel = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_address <= 32'd0;
            cfg_reg.data_offset <= OFFSET_WIDTH'(0);
            cfg_reg.status_offset <= OFFSET_WIDTH'(4);
            cfg_reg.status_value <= 32'd0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_BASE_ADDRESS:  cfg_reg.base_address <= pwdata;
                REG_DATA_OFFSET:   cfg_reg.data_offset <= pwdata[OFFSET_WIDTH-1:0];
                REG_STATUS_OFFSET: cfg_reg.status_offset <= pwdata[OFFSET_WIDTH-1:0];
                REG_STATUS_VALUE:  cfg_reg.status_value <= pwdata;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_BASE_ADDRESS:  prdata = cfg_reg.base_address;
            REG_DATA_OFFSET:   prdata = {{(32-OFFSET_WIDTH){1'b0}}, cfg_reg.data_offset};
            REG_STATUS_OFFSET: prdata = {{(32-OFFSET_WIDTH){1'b0}}, cfg_reg.status_offset};
            REG_STATUS_VALUE:  prdata = cfg_reg.status_value;
            default:           prdata = 32'd0;
        endcase
    end

    lbcu_front u_front (
        .push    (push),
        .full    (full),
        .request (request),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_wr_cmd)
    );

    lbcu_cmd_queue u_cmd_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_cmd (q_wr_cmd),
        .full   (q_full),
        .pop    (q_pop),
        .rd_cmd (q_rd_cmd),
        .empty  (q_empty)
    );

    lbcu_back #(
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_rd_cmd),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire
